// ----- hw/rtl/bttc_pkg.sv -----
`timescale 1ns / 1ps
package bttc_pkg;

  localparam logic [1:0] FMT_RAW = 2'd0;
  localparam logic [1:0] FMT_B64 = 2'd1;
  localparam logic [1:0] FMT_B85 = 2'd2;
  localparam logic [1:0] FMT_HEX = 2'd3;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_SYMBOL = 2'd1;
  localparam logic [1:0] ERR_INCOMPLETE = 2'd2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [6:0] B85_RADIX = 7'd85;
  localparam logic [6:0] B85_TOP_DIGIT = 7'd84;
  localparam logic [5:0] B64_MASK = 6'h3F;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW = 1;

  localparam logic [0:0] ADDR_FORMAT = 1'b0;
  localparam logic [0:0] ADDR_DIRECTION = 1'b1;

  // Job kinds handed from the front to the back.
  typedef enum logic [2:0] {
    JOB_BYTES,    // up to four literal bytes in job_data
    JOB_B64_ENC,  // four base64 characters from a 24-bit value
    JOB_B85_ENC,  // digits of a 32-bit value, count in job_count
    JOB_HEX_ENC   // two hex characters of one byte
  } job_kind_t;

  // One unit of work: a group of output characters or bytes.
  typedef struct packed {
    job_kind_t   kind;
    logic [31:0] data;
    logic [2:0]  count;   // number of results (0 means bare marker)
    logic [1:0]  b64_pad; // base64 encode: number of '=' in the tail
    logic        last;
    logic [1:0]  err;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) c = 8'h41 + {2'b00, v};
    else if (v < 6'd52) c = 8'h61 + {2'b00, v} - 8'd26;
    else if (v < 6'd62) c = 8'h30 + {2'b00, v} - 8'd52;
    else if (v == 6'd62) c = 8'h2B;
    else c = 8'h2F;
    return c;
  endfunction

  function automatic logic [7:0] b85_char(input logic [6:0] v);
    logic [7:0] c;
    if (v < 7'd10) c = 8'h30 + {1'b0, v};
    else if (v < 7'd36) c = 8'h41 + {1'b0, v} - 8'd10;
    else if (v < 7'd62) c = 8'h61 + {1'b0, v} - 8'd36;
    else begin
      case (v)
        7'd62: c = 8'h21;
        7'd63: c = 8'h23;
        7'd64: c = 8'h24;
        7'd65: c = 8'h25;
        7'd66: c = 8'h26;
        7'd67: c = 8'h28;
        7'd68: c = 8'h29;
        7'd69: c = 8'h2A;
        7'd70: c = 8'h2B;
        7'd71: c = 8'h2D;
        7'd72: c = 8'h3B;
        7'd73: c = 8'h3C;
        7'd74: c = 8'h3D;
        7'd75: c = 8'h3E;
        7'd76: c = 8'h3F;
        7'd77: c = 8'h40;
        7'd78: c = 8'h5E;
        7'd79: c = 8'h5F;
        7'd80: c = 8'h60;
        7'd81: c = 8'h7B;
        7'd82: c = 8'h7C;
        7'd83: c = 8'h7D;
        default: c = 8'h7E;
      endcase
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h61 + {4'h0, v} - 8'd10);
  endfunction

  // Returns {valid, value}.
  function automatic logic [6:0] b64_val(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5A) r = {1'b1, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    else if (c == 8'h2B) r = {1'b1, 6'd62};
    else if (c == 8'h2F) r = {1'b1, 6'd63};
    else r = 7'd0;
    return r;
  endfunction

  function automatic logic [7:0] b85_val(input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 7'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h5A) r = {1'b1, 7'(c - 8'h41 + 8'd10)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 7'(c - 8'h61 + 8'd36)};
    else begin
      case (c)
        8'h21: r = {1'b1, 7'd62};
        8'h23: r = {1'b1, 7'd63};
        8'h24: r = {1'b1, 7'd64};
        8'h25: r = {1'b1, 7'd65};
        8'h26: r = {1'b1, 7'd66};
        8'h28: r = {1'b1, 7'd67};
        8'h29: r = {1'b1, 7'd68};
        8'h2A: r = {1'b1, 7'd69};
        8'h2B: r = {1'b1, 7'd70};
        8'h2D: r = {1'b1, 7'd71};
        8'h3B: r = {1'b1, 7'd72};
        8'h3C: r = {1'b1, 7'd73};
        8'h3D: r = {1'b1, 7'd74};
        8'h3E: r = {1'b1, 7'd75};
        8'h3F: r = {1'b1, 7'd76};
        8'h40: r = {1'b1, 7'd77};
        8'h5E: r = {1'b1, 7'd78};
        8'h5F: r = {1'b1, 7'd79};
        8'h60: r = {1'b1, 7'd80};
        8'h7B: r = {1'b1, 7'd81};
        8'h7C: r = {1'b1, 7'd82};
        8'h7D: r = {1'b1, 7'd83};
        8'h7E: r = {1'b1, 7'd84};
        default: r = 8'd0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    else r = 5'd0;
    return r;
  endfunction

endpackage

// ----- hw/rtl/bttc_in_if.sv -----
`timescale 1ns / 1ps
interface bttc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source(output valid, output in_byte, output in_last, input ready);
  modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

// ----- hw/rtl/bttc_out_if.sv -----
`timescale 1ns / 1ps
interface bttc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       run_end;
  logic       frame_end;
  logic [1:0] error_code;
  modport source(output valid, output out_byte, output has_byte, output run_end,
                 output frame_end, output error_code, input ready);
  modport sink(input valid, input out_byte, input has_byte, input run_end,
               input frame_end, input error_code, output ready);
endinterface

// ----- hw/rtl/binary_to_text_codec_unit.sv -----
`timescale 1ns / 1ps
// Binary-to-text codec: raw, base64, base85 or lowercase hex, encode or decode,
// selected by the format (byte 0) and direction (byte 4) registers on the APB
// port. Any register write aborts the frame in progress. Input items arrive
// on in_ch one per transfer; results leave on out_ch, one result per transfer
// at most one per cycle. The front takes one item a cycle for most modes while
// the queue has room (base85 decode holds each item for a multiply-add step
// before the next, plus a padding loop for a short tail); the back emits one
// result per cycle while out_ch is ready, so hex encode is paced by the back.
// Base85 encode first extracts digits through a reciprocal-multiply divider.
module binary_to_text_codec_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bttc_in_if.sink     in_ch,
  bttc_out_if.source  out_ch
);
  import bttc_pkg::*;

  logic [1:0] format;
  logic       direction;
  logic       cfg_write;
  logic       cfg_clear;
  logic       front_valid;
  logic       q_can_push;
  logic       q_can_pop;
  logic       q_pop;
  job_t       front_job;
  job_t       q_job;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  // Only a write to a real register aborts the frame.
  assign cfg_clear = cfg_write && paddr[1:0] == 2'b00 && paddr[2] <= ADDR_DIRECTION;

  always_ff @(posedge clk) begin
    if (rst) begin
      format <= FMT_RAW;
      direction <= 1'b0;
    end else if (cfg_write && paddr[1:0] == 2'b00) begin
      if (paddr[2] == ADDR_FORMAT) format <= pwdata[1:0];
      else direction <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ADDR_FORMAT) prdata = {30'd0, format};
    else prdata = {31'd0, direction};
  end

  bttc_front u_front (
    .clk(clk), .rst(rst), .format(format), .direction(direction),
    .cfg_clear(cfg_clear), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_byte(in_ch.in_byte), .in_last(in_ch.in_last),
    .job_valid(front_valid), .job_ready(q_can_push), .job(front_job)
  );

  bttc_queue u_queue (
    .clk(clk), .rst(rst), .flush(cfg_clear), .push(front_valid),
    .can_push(q_can_push), .push_job(front_job), .can_pop(q_can_pop),
    .pop(q_pop), .pop_job(q_job)
  );

  bttc_back u_back (
    .clk(clk), .rst(rst), .flush(cfg_clear), .job_valid(q_can_pop),
    .job_pop(q_pop), .job(q_job), .res(out_ch)
  );
endmodule

// ----- hw/rtl/bttc_front.sv -----
`timescale 1ns / 1ps
module bttc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         format,
  input  logic               direction,
  input  logic               cfg_clear,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output logic               job_valid,
  input  logic               job_ready,
  output bttc_pkg::job_t     job
);
  import bttc_pkg::*;

  // Sequencer for base85 decode: multiply by 85, then add the digit.
  logic [31:0] group_value;
  logic [2:0]  group_position;
  logic [1:0]  pad_marks;
  logic [1:0]  frame_error;

  // Held base85 decode item between the multiply and the add.
  logic        b85_busy;
  logic [31:0] b85_prod;
  logic [6:0]  b85_digit;
  logic        b85_last;
  logic [1:0]  b85_err;
  // Tail padding loop: multiply-by-85-add-84 one step a cycle.
  logic        tail_busy;
  logic [2:0]  tail_k;
  logic [2:0]  tail_n;
  logic [31:0] tail_acc;
  logic [1:0]  tail_err;

  logic [31:0] gv_next;
  logic [2:0]  gp_next;
  logic [1:0]  pm_next;
  logic [1:0]  fe_next;
  logic        emit;
  job_t        j;
  logic        take;
  logic [6:0]  v64;
  logic [7:0]  v85;
  logic [4:0]  v16;
  logic [1:0]  fe_tmp;
  logic [31:0] sum85;

  // A job waits here if the queue is full.
  logic job_valid_hold;
  job_t job_hold;

  assign v64 = b64_val(in_byte);
  assign v85 = b85_val(in_byte);
  assign v16 = hex_val(in_byte);
  assign sum85 = b85_prod + {25'd0, b85_digit};

  assign in_ready = !b85_busy && !tail_busy && !job_valid_hold;

  assign take = in_valid && in_ready;

  always_comb begin
    gv_next = group_value;
    gp_next = group_position;
    pm_next = pad_marks;
    fe_next = frame_error;
    emit = 1'b0;
    j = '0;
    j.kind = JOB_BYTES;
    j.last = in_last;
    fe_tmp = frame_error;
    if (!direction) begin
      case (format)
        FMT_RAW: begin
          emit = 1'b1;
          j.data = {in_byte, 24'd0};
          j.count = 3'd1;
        end
        FMT_HEX: begin
          emit = 1'b1;
          j.kind = JOB_HEX_ENC;
          j.data = {in_byte, 24'd0};
          j.count = 3'd2;
        end
        FMT_B64: begin
          gv_next = {8'd0, group_value[15:0], in_byte};
          gp_next = group_position + 3'd1;
          j.kind = JOB_B64_ENC;
          if (gp_next >= 3'd3) begin
            emit = 1'b1;
            j.data = gv_next;
            j.count = 3'd4;
            gv_next = '0;
            gp_next = '0;
          end else if (in_last) begin
            emit = 1'b1;
            j.count = 3'd4;
            if (gp_next == 3'd1) begin
              j.data = {8'd0, in_byte, 16'd0};
              j.b64_pad = 2'd2;
            end else begin
              j.data = {8'd0, group_value[7:0], in_byte, 8'd0};
              j.b64_pad = 2'd1;
            end
          end
        end
        default: begin
          gv_next = {group_value[23:0], in_byte};
          gp_next = group_position + 3'd1;
          j.kind = JOB_B85_ENC;
          if (gp_next >= 3'd4) begin
            emit = 1'b1;
            j.data = gv_next;
            j.count = 3'd5;
            gv_next = '0;
            gp_next = '0;
          end else if (in_last) begin
            emit = 1'b1;
            j.data = gv_next << (6'd8 * {3'd0, 3'd4 - gp_next});
            j.count = gp_next + 3'd1;
          end
        end
      endcase
    end else begin
      case (format)
        FMT_RAW: begin
          emit = 1'b1;
          j.data = {in_byte, 24'd0};
          j.count = 3'd1;
        end
        FMT_HEX: begin
          if (!v16[4] && fe_tmp == ERR_NONE) fe_tmp = ERR_SYMBOL;
          gv_next = {24'd0, group_value[3:0], v16[3:0]};
          gp_next = group_position + 3'd1;
          if (gp_next >= 3'd2) begin
            emit = 1'b1;
            j.data = {gv_next[7:0], 24'd0};
            j.count = 3'd1;
            gv_next = '0;
            gp_next = '0;
          end else if (in_last && fe_tmp == ERR_NONE) begin
            fe_tmp = ERR_INCOMPLETE;
          end
          fe_next = fe_tmp;
        end
        FMT_B64: begin
          if (in_byte == PAD_CHAR) begin
            if (group_position < 3'd2) begin
              if (fe_tmp == ERR_NONE) fe_tmp = ERR_SYMBOL;
            end else if (group_position == 3'd2) begin
              pm_next[0] = 1'b1;
            end else begin
              pm_next[1] = 1'b1;
            end
            gv_next = {8'd0, group_value[17:0], 6'd0};
          end else begin
            if (!v64[6] && fe_tmp == ERR_NONE) fe_tmp = ERR_SYMBOL;
            if (pad_marks != 2'd0 && fe_tmp == ERR_NONE) fe_tmp = ERR_SYMBOL;
            gv_next = {8'd0, group_value[17:0], v64[5:0]};
          end
          gp_next = group_position + 3'd1;
          if (gp_next >= 3'd4) begin
            emit = 1'b1;
            // Pack surviving bytes at the top, in order.
            j.count = 3'd1 + {2'd0, !pm_next[0]} + {2'd0, !pm_next[1]};
            j.data[31:24] = gv_next[23:16];
            if (!pm_next[0]) begin
              j.data[23:16] = gv_next[15:8];
              j.data[15:8] = gv_next[7:0];
            end else begin
              j.data[23:16] = gv_next[7:0];
            end
            if (pm_next != 2'd0 && !in_last && fe_tmp == ERR_NONE) fe_tmp = ERR_SYMBOL;
            gv_next = '0;
            gp_next = '0;
            pm_next = '0;
          end else if (in_last && fe_tmp == ERR_NONE) begin
            fe_tmp = ERR_INCOMPLETE;
          end
          fe_next = fe_tmp;
        end
        default: begin
          // Handled by the base85 sequencer.
        end
      endcase
    end
    j.err = fe_next;
    if (in_last && !emit) begin
      emit = 1'b1;
      j.kind = JOB_BYTES;
      j.count = 3'd0;
    end
  end

  logic is_b85_dec;
  assign is_b85_dec = direction && format == FMT_B85;

  // Second-stage base85 decode outcome.
  logic [1:0]  b85_fe;
  logic [2:0]  b85_gp;
  always_comb begin
    b85_fe = b85_err;
    b85_gp = group_position + 3'd1;
  end

  job_t q_job;
  logic q_push;

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      group_value <= '0;
      group_position <= '0;
      pad_marks <= '0;
      frame_error <= '0;
      b85_busy <= 1'b0;
      tail_busy <= 1'b0;
      job_valid_hold <= 1'b0;
    end else begin
      if (job_valid_hold && job_ready) job_valid_hold <= 1'b0;
      if (take && !is_b85_dec) begin
        // Drop the partial group at the end of a frame.
        group_value <= in_last ? '0 : gv_next;
        group_position <= in_last ? '0 : gp_next;
        pad_marks <= in_last ? '0 : pm_next;
        frame_error <= in_last ? ERR_NONE : fe_next;
        if (emit && !job_ready) begin
          job_valid_hold <= 1'b1;
          job_hold <= j;
        end
      end
      if (take && is_b85_dec) begin
        b85_busy <= 1'b1;
        b85_prod <= group_value * 32'(B85_RADIX);
        b85_digit <= v85[7] ? v85[6:0] : 7'd0;
        b85_last <= in_last;
        b85_err <= (!v85[7] && frame_error == ERR_NONE) ? ERR_SYMBOL : frame_error;
      end
      if (b85_busy) begin
        if (b85_gp >= 3'd5) begin
          if (job_ready) begin
            b85_busy <= 1'b0;
            group_value <= '0;
            group_position <= '0;
            frame_error <= b85_last ? ERR_NONE : b85_fe;
          end
        end else if (b85_last) begin
          if (b85_gp < 3'd2) begin
            if (job_ready) begin
              b85_busy <= 1'b0;
              group_value <= '0;
              group_position <= '0;
              frame_error <= ERR_NONE;
            end
          end else begin
            b85_busy <= 1'b0;
            tail_busy <= 1'b1;
            tail_acc <= sum85;
            tail_k <= b85_gp;
            tail_n <= b85_gp;
            tail_err <= b85_fe;
            group_value <= '0;
            group_position <= '0;
          end
        end else begin
          b85_busy <= 1'b0;
          group_value <= sum85;
          group_position <= b85_gp;
          frame_error <= b85_fe;
        end
      end
      if (tail_busy) begin
        if (tail_k < 3'd5) begin
          tail_acc <= tail_acc * 32'(B85_RADIX) + 32'(B85_TOP_DIGIT);
          tail_k <= tail_k + 3'd1;
        end else if (job_ready) begin
          tail_busy <= 1'b0;
          frame_error <= ERR_NONE;
        end
      end
    end
  end

  always_comb begin
    q_push = 1'b0;
    q_job = j;
    if (job_valid_hold) begin
      q_push = 1'b1;
      q_job = job_hold;
    end else if (take && !is_b85_dec) begin
      q_push = emit;
    end else if (b85_busy) begin
      q_job = '0;
      q_job.kind = JOB_BYTES;
      q_job.last = b85_last;
      q_job.err = (b85_gp < 3'd2 && b85_last && b85_fe == ERR_NONE) ? ERR_INCOMPLETE
                                                                       : b85_fe;
      if (b85_gp >= 3'd5) begin
        q_push = 1'b1;
        q_job.data = sum85;
        q_job.count = 3'd4;
      end else if (b85_last && b85_gp < 3'd2) begin
        q_push = 1'b1;
        q_job.count = 3'd0;
      end
    end else if (tail_busy && tail_k >= 3'd5) begin
      q_push = 1'b1;
      q_job = '0;
      q_job.kind = JOB_BYTES;
      q_job.data = tail_acc;
      q_job.count = tail_n - 3'd1;
      q_job.last = 1'b1;
      q_job.err = tail_err;
    end
  end

  assign job_valid = q_push;
  assign job = q_job;

  assert property (@(posedge clk) disable iff (rst) !(b85_busy && tail_busy))
    else $error("base85 stages overlap");
  assert property (@(posedge clk) disable iff (rst)
      job_valid && job.kind == JOB_B85_ENC |-> job.count >= 3'd2)
    else $error("base85 encode job too short");
  assert property (@(posedge clk) disable iff (rst) group_position <= 3'd4)
    else $error("group position overrun");
endmodule

// ----- hw/rtl/bttc_queue.sv -----
`timescale 1ns / 1ps
module bttc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           flush,
  input  logic           push,
  output logic           can_push,
  input  bttc_pkg::job_t push_job,
  output logic           can_pop,
  input  logic           pop,
  output bttc_pkg::job_t pop_job
);
  import bttc_pkg::*;

  job_t             slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign can_push = fill < (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign can_pop = fill != '0;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push && can_push) begin
        slots[wr_ptr] <= push_job;
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && can_pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QUEUE_AW+1)'(push && can_push) - (QUEUE_AW+1)'(pop && can_pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue overfilled");
endmodule

// ----- hw/rtl/bttc_back.sv -----
`timescale 1ns / 1ps
module bttc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           flush,
  input  logic           job_valid,
  output logic           job_pop,
  input  bttc_pkg::job_t job,
  bttc_out_if.source     res
);
  import bttc_pkg::*;

  // Base85 encode: one digit per cycle, least significant first, into a buffer.
  logic [2:0]  idx;
  logic        digits_done;
  logic [2:0]  dig_cnt;
  logic [31:0] rem_val;
  logic [6:0]  digits [5];
  logic [31:0] quot;
  logic [6:0]  rmd;
  logic [7:0]  ch;
  logic        adv;
  logic        final_item;
  logic        need_digits;
  logic [39:0] prod;

  assign need_digits = job.kind == JOB_B85_ENC && !digits_done;
  // Divide by 85 via reciprocal ceil(2^38/85) = 3233857729, exact for 32 bits.
  assign prod = 40'((64'(rem_val) * 64'd3233857729) >> 32);
  assign quot = 32'(prod >> 6);
  assign rmd = 7'(rem_val - quot * 32'(B85_RADIX));

  always_comb begin
    ch = 8'h00;
    case (job.kind)
      JOB_BYTES: ch = job.data[31 - 8*idx[1:0] -: 8];
      JOB_HEX_ENC: ch = hex_char(idx[0] ? job.data[27:24] : job.data[31:28]);
      JOB_B64_ENC: begin
        if ({1'b0, idx} >= 4'd4 - {2'd0, job.b64_pad}) ch = PAD_CHAR;
        else ch = b64_char(6'(job.data >> (5'd18 - 5'd6 * {2'd0, idx[1:0]})) & B64_MASK);
      end
      default: ch = b85_char(digits[idx]);
    endcase
  end

  assign final_item = (job.count == 3'd0) || (idx + 3'd1 == job.count);
  assign adv = job_valid && !need_digits && (!res.valid || res.ready);
  assign job_pop = adv && final_item;

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      idx <= '0;
      digits_done <= 1'b0;
      dig_cnt <= '0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready) res.valid <= 1'b0;
      if (job_valid && need_digits) begin
        if (dig_cnt == 3'd0) begin
          rem_val <= job.data;
          dig_cnt <= 3'd5;
        end else begin
          digits[dig_cnt - 3'd1] <= rmd;
          rem_val <= quot;
          dig_cnt <= dig_cnt - 3'd1;
          if (dig_cnt == 3'd1) digits_done <= 1'b1;
        end
      end
      if (adv) begin
        res.valid <= 1'b1;
        res.out_byte <= job.count == 3'd0 ? 8'h00 : ch;
        res.has_byte <= job.count != 3'd0;
        res.run_end <= final_item;
        res.frame_end <= final_item && job.last;
        res.error_code <= (final_item && job.last) ? job.err : ERR_NONE;
        if (final_item) begin
          idx <= '0;
          digits_done <= 1'b0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) res.valid && !res.frame_end
      |-> res.error_code == ERR_NONE)
    else $error("error outside frame end");
  assert property (@(posedge clk) disable iff (rst) res.valid && !res.has_byte
      |-> res.frame_end && res.run_end)
    else $error("bare marker not at frame end");
  assert property (@(posedge clk) disable iff (rst) idx <= 3'd4)
    else $error("result index overrun");
endmodule

// ----- tb/tb_binary_to_text_codec_unit.sv -----
`timescale 1ns / 1ps
module tb_binary_to_text_codec_unit;
  import bttc_pkg::*;

  localparam logic [2:0] REG_FORMAT_ADDR    = 3'd0;
  localparam logic [2:0] REG_DIRECTION_ADDR = 3'd4;
  localparam int IDLE_PCT       = 12;
  localparam int SETTLE_CYCLES  = 40;
  localparam int STALL_LIMIT    = 3000;
  localparam int RANDOM_ITEMS   = 440;
  localparam int CALM_FROM      = 2000;
  localparam int CALM_TO        = 3500;

  localparam string B64_SYMS = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam string B85_SYMS =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz!#$%&()*+-;<=>?@^_`{|}~";
  localparam string HEX_SYMS = "0123456789abcdef";
  localparam string HEX_UPPER = "0123456789ABCDEF";

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } text_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_end;
    logic       frame_end;
    logic [1:0] error_code;
  } codec_result_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bttc_in_if  in_ch();
  bttc_out_if out_ch();

  binary_to_text_codec_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // Byte stream waiting for the driver and results still owed by the block.
  text_item_t    pending_items[$];
  codec_result_t due_results[$];
  codec_result_t step_results[$];

  // Shadow of the block: mode registers and the group being gathered.
  logic [1:0]  sh_format;
  logic        sh_direction;
  bit   [31:0] sh_group;
  int unsigned sh_pos;
  logic [1:0]  sh_pads;
  logic [1:0]  sh_error;

  logic in_fire;
  int   cycle_count;
  int   stall_count;
  int   fail_count;
  int   items_sent;
  int   results_seen;
  int   frames_seen;
  logic calm;

  assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void clear_group();
    sh_group = '0;
    sh_pos   = 0;
    sh_pads  = '0;
    sh_error = ERR_NONE;
  endfunction

  function automatic void note_error(logic [1:0] code);
    // keep the first error of the frame
    if (sh_error == ERR_NONE) sh_error = code;
  endfunction

  function automatic void put_byte(bit [7:0] b);
    codec_result_t r;
    r = '0;
    r.out_byte = b;
    r.has_byte = 1'b1;
    step_results.push_back(r);
  endfunction

  function automatic int sym_index(string syms, bit [7:0] c);
    for (int i = 0; i < syms.len(); i++)
      if (syms[i] == c) return i;
    return -1;
  endfunction

  function automatic void put_b85(bit [31:0] v, int count);
    bit [6:0] digits[5];
    for (int j = 4; j >= 0; j--) begin
      digits[j] = 7'(v % 85);
      v = v / 85;
    end
    for (int k = 0; k < count; k++) put_byte(B85_SYMS[digits[k]]);
  endfunction

  function automatic void put_b64(bit [23:0] v, int nbytes);
    put_byte(B64_SYMS[v[23:18]]);
    put_byte(B64_SYMS[v[17:12]]);
    put_byte(nbytes >= 2 ? B64_SYMS[v[11:6]] : PAD_CHAR);
    put_byte(nbytes >= 3 ? B64_SYMS[v[5:0]] : PAD_CHAR);
  endfunction

  function automatic void encode_step(bit [7:0] b, bit last);
    case (sh_format)
      FMT_RAW: put_byte(b);
      FMT_HEX: begin
        put_byte(HEX_SYMS[b[7:4]]);
        put_byte(HEX_SYMS[b[3:0]]);
      end
      FMT_B64: begin
        sh_group = {8'h00, sh_group[15:0], b};
        sh_pos++;
        if (sh_pos >= 3) begin
          put_b64(sh_group[23:0], 3);
          sh_group = '0;
          sh_pos = 0;
        end else if (last) begin
          put_b64(24'(sh_group << (8 * (3 - sh_pos))), sh_pos);
        end
      end
      default: begin
        sh_group = {sh_group[23:0], b};
        sh_pos++;
        if (sh_pos >= 4) begin
          put_b85(sh_group, 5);
          sh_group = '0;
          sh_pos = 0;
        end else if (last) begin
          put_b85(sh_group << (8 * (4 - sh_pos)), sh_pos + 1);
        end
      end
    endcase
  endfunction

  function automatic void decode_step(bit [7:0] c, bit last);
    int          idx;
    bit   [31:0] v;
    bit   [31:0] full;
    case (sh_format)
      FMT_RAW: put_byte(c);
      FMT_HEX: begin
        idx = sym_index(HEX_SYMS, c);
        if (idx < 0) idx = sym_index(HEX_UPPER, c);
        if (idx < 0) begin
          note_error(ERR_SYMBOL);
          idx = 0;
        end
        sh_group = {24'h0, sh_group[3:0], 4'(idx)};
        sh_pos++;
        if (sh_pos >= 2) begin
          put_byte(sh_group[7:0]);
          sh_group = '0;
          sh_pos = 0;
        end else if (last) begin
          note_error(ERR_INCOMPLETE);
        end
      end
      FMT_B64: begin
        if (c == PAD_CHAR) begin
          if (sh_pos < 2) note_error(ERR_SYMBOL);
          else sh_pads[sh_pos - 2] = 1'b1;
          idx = 0;
        end else begin
          idx = sym_index(B64_SYMS, c);
          if (idx < 0) begin
            note_error(ERR_SYMBOL);
            idx = 0;
          end
          if (sh_pads != 0) note_error(ERR_SYMBOL);
        end
        sh_group = {8'h00, sh_group[17:0], 6'(idx)};
        sh_pos++;
        if (sh_pos >= 4) begin
          put_byte(sh_group[23:16]);
          if (!sh_pads[0]) put_byte(sh_group[15:8]);
          if (!sh_pads[1]) put_byte(sh_group[7:0]);
          if (sh_pads != 0 && !last) note_error(ERR_SYMBOL);
          sh_group = '0;
          sh_pos = 0;
          sh_pads = '0;
        end else if (last) begin
          note_error(ERR_INCOMPLETE);
        end
      end
      default: begin
        idx = sym_index(B85_SYMS, c);
        if (idx < 0) begin
          note_error(ERR_SYMBOL);
          idx = 0;
        end
        v = idx;
        sh_group = sh_group * 85 + v;
        sh_pos++;
        if (sh_pos >= 5) begin
          put_byte(sh_group[31:24]);
          put_byte(sh_group[23:16]);
          put_byte(sh_group[15:8]);
          put_byte(sh_group[7:0]);
          sh_group = '0;
          sh_pos = 0;
        end else if (last) begin
          if (sh_pos < 2) begin
            note_error(ERR_INCOMPLETE);
          end else begin
            // short tail: fill with the top digit, keep one byte less than chars
            full = sh_group;
            for (int k = sh_pos; k < 5; k++) full = full * 85 + 84;
            for (int k = 0; k + 1 < sh_pos; k++) put_byte(8'(full >> (24 - 8 * k)));
          end
        end
      end
    endcase
  endfunction

  function automatic void codec_predict(text_item_t it);
    codec_result_t r;
    step_results.delete();
    if (!sh_direction) encode_step(it.b, it.last);
    else decode_step(it.b, it.last);
    if (it.last && step_results.size() == 0) begin
      r = '0;
      step_results.push_back(r);
    end
    if (step_results.size() == 0) return;
    r = step_results[$];
    r.run_end = 1'b1;
    if (it.last) begin
      r.frame_end  = 1'b1;
      r.error_code = sh_error;
      clear_group();
    end
    step_results[step_results.size() - 1] = r;
    foreach (step_results[i]) due_results.push_back(step_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: advance on a transfer, idle now and then, stall the result side
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive
    text_item_t nxt;
    if (!rst) begin
      if (!in_ch.valid || in_fire) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_items.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.in_byte <= nxt.b;
          in_ch.in_last <= nxt.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each input transfer, check each output transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    text_item_t    it;
    codec_result_t want;
    logic          got_in;
    logic          got_out;
    got_in  = in_ch.valid && in_ch.ready && !rst;
    got_out = out_ch.valid && out_ch.ready && !rst;
    in_fire <= got_in;
    cycle_count <= cycle_count + 1;
    if (got_in) begin
      it.b    = in_ch.in_byte;
      it.last = in_ch.in_last;
      codec_predict(it);
      items_sent <= items_sent + 1;
    end
    if (got_out) begin
      results_seen <= results_seen + 1;
      if (out_ch.frame_end) frames_seen <= frames_seen + 1;
      if (due_results.size() == 0) begin
        $error("unexpected result: out_byte %h frame_end %b", out_ch.out_byte,
               out_ch.frame_end);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (out_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_ch.out_byte);
          fail_count++;
        end
        if (out_ch.has_byte !== want.has_byte) begin
          $error("has_byte: expected %b, got %b", want.has_byte, out_ch.has_byte);
          fail_count++;
        end
        if (out_ch.run_end !== want.run_end) begin
          $error("run_end: expected %b, got %b", want.run_end, out_ch.run_end);
          fail_count++;
        end
        if (out_ch.frame_end !== want.frame_end) begin
          $error("frame_end: expected %b, got %b", want.frame_end, out_ch.frame_end);
          fail_count++;
        end
        if (out_ch.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_ch.error_code);
          fail_count++;
        end
      end
    end
    // watchdog: count cycles with no transfer on either channel
    if (got_in || got_out || rst) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Both writes clear the group, so a frame left open is dropped here.
  task automatic set_mode(logic [1:0] fmt, logic dir);
    reg_write(REG_FORMAT_ADDR, {$urandom_range(1) ? $urandom() : 32'h0} & 32'hFFFF_FFFC | fmt);
    sh_format = fmt;
    clear_group();
    reg_write(REG_DIRECTION_ADDR, {31'h0, dir});
    sh_direction = dir;
    clear_group();
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || due_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void push_text(string s, bit close);
    text_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.b    = s[i];
      it.last = close && (i == s.len() - 1);
      pending_items.push_back(it);
    end
  endfunction

  function automatic void push_bytes(bit [7:0] q[$]);
    text_item_t it;
    foreach (q[i]) begin
      it.b    = q[i];
      it.last = (i == q.size() - 1);
      pending_items.push_back(it);
    end
  endfunction

  // Well-formed text for the current mode, with some noise and broken tails.
  function automatic int queue_frame(logic [1:0] fmt, logic dir);
    bit [7:0] q[$];
    int groups;
    int tail;
    if (!dir || fmt == FMT_RAW) begin
      repeat ($urandom_range(1, 9)) q.push_back(8'($urandom()));
    end else if (fmt == FMT_HEX) begin
      repeat (2 * $urandom_range(1, 5))
        q.push_back($urandom_range(1) ? HEX_SYMS[$urandom_range(15)]
                                      : HEX_UPPER[$urandom_range(15)]);
    end else if (fmt == FMT_B64) begin
      groups = $urandom_range(0, 2);
      tail   = (groups == 0) ? $urandom_range(1, 3) : $urandom_range(0, 3);
      repeat (4 * groups) q.push_back(B64_SYMS[$urandom_range(63)]);
      if (tail == 1) begin
        repeat (4) q.push_back(B64_SYMS[$urandom_range(63)]);
      end else if (tail == 2) begin
        repeat (2) q.push_back(B64_SYMS[$urandom_range(63)]);
        repeat (2) q.push_back(PAD_CHAR);
      end else if (tail == 3) begin
        repeat (3) q.push_back(B64_SYMS[$urandom_range(63)]);
        q.push_back(PAD_CHAR);
      end
    end else begin
      groups = $urandom_range(0, 2);
      case ($urandom_range(5))
        0, 1: tail = 0;
        2: tail = 2;
        3: tail = 3;
        4: tail = 4;
        default: tail = 1;
      endcase
      if (groups == 0 && tail == 0) groups = 1;
      repeat (5 * groups + tail) q.push_back(B85_SYMS[$urandom_range(84)]);
    end
    if (dir) begin
      // noise: stray symbol, misplaced pad, or a cut-off group
      if ($urandom_range(99) < 12) q[$urandom_range(q.size() - 1)] = 8'($urandom());
      if ($urandom_range(99) < 6) q[$urandom_range(q.size() - 1)] = PAD_CHAR;
      if ($urandom_range(99) < 8 && q.size() > 1) void'(q.pop_back());
    end
    push_bytes(q);
    return q.size();
  endfunction

  initial begin : stimulus
    int made;
    int got;
    int phase;
    logic [1:0] fmt;
    logic dir;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    out_ch.ready = 1'b0;
    in_fire = 1'b0;
    cycle_count = 0;
    stall_count = 0;
    fail_count = 0;
    items_sent = 0;
    results_seen = 0;
    frames_seen = 0;
    sh_format = FMT_RAW;
    sh_direction = 1'b0;
    clear_group();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed: byte extremes, padding, overflow, errors, aborted frame.
    set_mode(FMT_HEX, 1'b0);
    push_bytes('{8'h00, 8'hFF});
    drain();
    set_mode(FMT_B64, 1'b0);
    push_bytes('{8'hFF});
    drain();
    set_mode(FMT_B85, 1'b0);
    push_bytes('{8'h00});
    drain();
    set_mode(FMT_B64, 1'b1);
    push_text("=AAA", 1);        // pad in the first slot
    push_text("QQ==", 1);        // proper padded tail
    push_text("AB", 0);          // left open, dropped by the next write
    drain();
    set_mode(FMT_B85, 1'b1);
    push_text("~~~~~", 1);       // value past 32 bits wraps
    push_text("A", 1);           // single tail digit
    drain();
    set_mode(FMT_HEX, 1'b1);
    push_text("zz1", 1);         // bad symbol first, then a lone nibble
    drain();

    // Random phases: walk every mode once, then pick at random.
    made = 0;
    phase = 0;
    while (made < RANDOM_ITEMS) begin
      if (phase < 8) begin
        fmt = phase[1:0];
        dir = phase[2];
      end else begin
        fmt = 2'($urandom_range(3));
        dir = 1'($urandom_range(1));
      end
      set_mode(fmt, dir);
      got = 0;
      while (got < 28) got += queue_frame(fmt, dir);
      while (pending_items.size() > 0) @(posedge clk);
      made += got;
      drain();
      phase++;
    end

    drain();
    $display("Covered %0d input transfers and %0d result transfers in %0d frames,",
             items_sent, results_seen, frames_seen);
    $display("across all formats in both directions over %0d mode settings.", phase + 6);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
